/* sv/fwpid_pkg.sv */
// Shared types, constants and register map of the four-wheel PID controller.
package fwpid_pkg;

    localparam int MAX_WHEELS   = 4;
    localparam int WHEELS_DEF   = 4;
    localparam int DUTY_SCALE_DEF = 10;

    localparam int FRAC_BITS = 20;
    localparam int SPEED_W   = 16;
    localparam int ERR_W     = 17;
    localparam int DIFF_W    = 18;
    localparam int SUM_W     = 32;
    localparam int GAIN_W    = 31;
    localparam int LIMIT_W   = 16;
    localparam int DUTY_W    = 36;
    localparam int INC_W     = 64;
    localparam int CMP_W     = 13;
    localparam int MODE_W    = 2;
    localparam int ADDR_W    = 5;
    localparam int DATA_W    = 32;
    localparam int STAGES    = 5;

    localparam logic [CMP_W-1:0]  CMP_MAX = '1;
    localparam logic [DUTY_W-1:0] TURN_DUTY_RESET = DUTY_W'(200) << FRAC_BITS;

    // mode codes
    localparam logic [MODE_W-1:0] MODE_DRIVE   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_TURN    = 2'd1;
    localparam logic [MODE_W-1:0] MODE_RESTART = 2'd2;
    localparam logic [MODE_W-1:0] MODE_SPARE   = 2'd3;

    // register indexes
    localparam logic [2:0] REG_DRIVE_P = 3'd0;
    localparam logic [2:0] REG_DRIVE_I = 3'd1;
    localparam logic [2:0] REG_DRIVE_D = 3'd2;
    localparam logic [2:0] REG_TURN_P  = 3'd3;
    localparam logic [2:0] REG_TURN_I  = 3'd4;
    localparam logic [2:0] REG_TURN_D  = 3'd5;
    localparam logic [2:0] REG_LIMIT   = 3'd6;

    localparam logic [GAIN_W-1:0]  DRIVE_P_RESET = 31'd11010048;
    localparam logic [GAIN_W-1:0]  DRIVE_I_RESET = 31'd105;
    localparam logic [GAIN_W-1:0]  DRIVE_D_RESET = 31'd104857600;
    localparam logic [GAIN_W-1:0]  TURN_P_RESET  = 31'd13631488;
    localparam logic [GAIN_W-1:0]  TURN_I_RESET  = 31'd105;
    localparam logic [GAIN_W-1:0]  TURN_D_RESET  = 31'd1048576000;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET   = 16'd10000;

    typedef struct packed {
        logic [MODE_W-1:0]  mode;
        logic [SPEED_W-1:0] speed_a;
        logic [SPEED_W-1:0] target_a;
        logic [SPEED_W-1:0] speed_b;
        logic [SPEED_W-1:0] target_b;
        logic [SPEED_W-1:0] speed_c;
        logic [SPEED_W-1:0] target_c;
        logic [SPEED_W-1:0] speed_d;
        logic [SPEED_W-1:0] target_d;
    } in_t;

    typedef struct packed {
        logic [CMP_W-1:0] compare_a;
        logic [CMP_W-1:0] compare_b;
        logic [CMP_W-1:0] compare_c;
        logic [CMP_W-1:0] compare_d;
    } out_t;

    typedef struct packed {
        logic [GAIN_W-1:0]  drive_p;
        logic [GAIN_W-1:0]  drive_i;
        logic [GAIN_W-1:0]  drive_d;
        logic [GAIN_W-1:0]  turn_p;
        logic [GAIN_W-1:0]  turn_i;
        logic [GAIN_W-1:0]  turn_d;
        logic [LIMIT_W-1:0] limit;
    } cfg_t;

    typedef struct packed {
        logic [GAIN_W-1:0] kp;
        logic [GAIN_W-1:0] ki;
        logic [GAIN_W-1:0] kd;
    } gains_t;

    // ld[0]: word enters stage 1; ld[k]: stage k hands its word on
    typedef struct packed {
        logic [STAGES-1:0] ld;
        logic              in_restart;
        logic              s1_turn;
        logic              s3_turn;
        logic              s3_restart;
    } ctrl_t;

endpackage

/* sv/fwpid_cfg.sv */
// APB register file holding the gain sets and the duty limit.
module fwpid_cfg
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [fwpid_pkg::ADDR_W-1:0]  paddr,
    input  logic [fwpid_pkg::DATA_W-1:0]  pwdata,
    output logic [fwpid_pkg::DATA_W-1:0]  prdata,
    output logic                          pready,
    output fwpid_pkg::cfg_t               cfg
);

    fwpid_pkg::cfg_t cfg_reg;
    logic [2:0]      idx;
    logic            wr_en;

    assign idx    = paddr[4:2];
    assign wr_en  = psel & penable & pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.drive_p <= fwpid_pkg::DRIVE_P_RESET;
            cfg_reg.drive_i <= fwpid_pkg::DRIVE_I_RESET;
            cfg_reg.drive_d <= fwpid_pkg::DRIVE_D_RESET;
            cfg_reg.turn_p  <= fwpid_pkg::TURN_P_RESET;
            cfg_reg.turn_i  <= fwpid_pkg::TURN_I_RESET;
            cfg_reg.turn_d  <= fwpid_pkg::TURN_D_RESET;
            cfg_reg.limit   <= fwpid_pkg::LIMIT_RESET;
        end
        else if (wr_en)
        begin
            unique case (idx)
                fwpid_pkg::REG_DRIVE_P: cfg_reg.drive_p <= pwdata[fwpid_pkg::GAIN_W-1:0];
                fwpid_pkg::REG_DRIVE_I: cfg_reg.drive_i <= pwdata[fwpid_pkg::GAIN_W-1:0];
                fwpid_pkg::REG_DRIVE_D: cfg_reg.drive_d <= pwdata[fwpid_pkg::GAIN_W-1:0];
                fwpid_pkg::REG_TURN_P:  cfg_reg.turn_p  <= pwdata[fwpid_pkg::GAIN_W-1:0];
                fwpid_pkg::REG_TURN_I:  cfg_reg.turn_i  <= pwdata[fwpid_pkg::GAIN_W-1:0];
                fwpid_pkg::REG_TURN_D:  cfg_reg.turn_d  <= pwdata[fwpid_pkg::GAIN_W-1:0];
                fwpid_pkg::REG_LIMIT:   cfg_reg.limit   <= pwdata[fwpid_pkg::LIMIT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            fwpid_pkg::REG_DRIVE_P: prdata = fwpid_pkg::DATA_W'(cfg_reg.drive_p);
            fwpid_pkg::REG_DRIVE_I: prdata = fwpid_pkg::DATA_W'(cfg_reg.drive_i);
            fwpid_pkg::REG_DRIVE_D: prdata = fwpid_pkg::DATA_W'(cfg_reg.drive_d);
            fwpid_pkg::REG_TURN_P:  prdata = fwpid_pkg::DATA_W'(cfg_reg.turn_p);
            fwpid_pkg::REG_TURN_I:  prdata = fwpid_pkg::DATA_W'(cfg_reg.turn_i);
            fwpid_pkg::REG_TURN_D:  prdata = fwpid_pkg::DATA_W'(cfg_reg.turn_d);
            fwpid_pkg::REG_LIMIT:   prdata = fwpid_pkg::DATA_W'(cfg_reg.limit);
            default:                prdata = '0;
        endcase
    end

endmodule

/* sv/fwpid_ctrl.sv */
// Pipeline valid/ready chain and per-stage mode flags.
module fwpid_ctrl
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          req_valid,
    output logic                          req_ready,
    input  logic [fwpid_pkg::MODE_W-1:0]  mode,
    output logic                          rsp_valid,
    input  logic                          rsp_ready,
    output fwpid_pkg::ctrl_t              ctrl
);

    localparam int N = fwpid_pkg::STAGES;

    logic [N-1:0] valid_reg, valid_next;
    logic [N-1:0] rdy;
    logic [N-1:0] ld;
    logic [2:0]   turn_reg, turn_next;
    logic [2:0]   restart_reg, restart_next;
    logic         in_turn, in_restart;

    always_comb
    begin
        unique case (mode) inside
            fwpid_pkg::MODE_TURN:
            begin
                in_turn    = 1'b1;
                in_restart = 1'b0;
            end
            fwpid_pkg::MODE_RESTART, fwpid_pkg::MODE_SPARE:
            begin
                in_turn    = 1'b0;
                in_restart = 1'b1;
            end
            default:
            begin
                in_turn    = 1'b0;
                in_restart = 1'b0;
            end
        endcase
    end

    // a stage takes a word when it is empty or its own word moves on
    always_comb
    begin
        rdy[N-1] = ~valid_reg[N-1] | rsp_ready;
        for (int k = N - 2; k >= 0; k--)
            rdy[k] = ~valid_reg[k] | rdy[k+1];
        ld[0] = req_valid & rdy[0];
        for (int k = 1; k < N; k++)
            ld[k] = valid_reg[k-1] & rdy[k];
        for (int k = 0; k < N; k++)
            valid_next[k] = rdy[k] ? ld[k] : valid_reg[k];
    end

    always_comb
    begin
        turn_next    = turn_reg;
        restart_next = restart_reg;
        if (ld[0])
        begin
            turn_next[0]    = in_turn;
            restart_next[0] = in_restart;
        end
        for (int k = 1; k < 3; k++)
        begin
            if (ld[k])
            begin
                turn_next[k]    = turn_reg[k-1];
                restart_next[k] = restart_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg   <= '0;
            turn_reg    <= '0;
            restart_reg <= '0;
        end
        else
        begin
            valid_reg   <= valid_next;
            turn_reg    <= turn_next;
            restart_reg <= restart_next;
        end
    end

    assign req_ready        = rdy[0];
    assign rsp_valid        = valid_reg[N-1];
    assign ctrl.ld          = ld;
    assign ctrl.in_restart  = in_restart;
    assign ctrl.s1_turn     = turn_reg[0];
    assign ctrl.s3_turn     = turn_reg[2];
    assign ctrl.s3_restart  = restart_reg[2];

endmodule

/* sv/fwpid_lane.sv */
// One wheel: error terms, gain products, duty accumulators, compare value.
module fwpid_lane
#(
    parameter int DUTY_SCALE = fwpid_pkg::DUTY_SCALE_DEF
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  fwpid_pkg::ctrl_t               ctrl,
    input  logic [fwpid_pkg::SPEED_W-1:0]  speed,
    input  logic [fwpid_pkg::SPEED_W-1:0]  target,
    input  fwpid_pkg::gains_t              gains,
    input  logic [fwpid_pkg::LIMIT_W-1:0]  limit,
    output logic [fwpid_pkg::CMP_W-1:0]    compare
);

    localparam int ERR_W  = fwpid_pkg::ERR_W;
    localparam int DIFF_W = fwpid_pkg::DIFF_W;
    localparam int SUM_W  = fwpid_pkg::SUM_W;
    localparam int GAIN_W = fwpid_pkg::GAIN_W;
    localparam int DUTY_W = fwpid_pkg::DUTY_W;
    localparam int INC_W  = fwpid_pkg::INC_W;
    localparam int FRAC   = fwpid_pkg::FRAC_BITS;
    localparam int X_W    = DUTY_W - FRAC;
    localparam int P_W    = GAIN_W + 1 + ERR_W;
    localparam int I_W    = GAIN_W + 1 + SUM_W;
    localparam int D_W    = GAIN_W + 1 + DIFF_W;
    localparam int ACC_W  = INC_W + 1;
    // floor(x / D) == (x * (floor(2^32 / D) + 1)) >> 32 for any 16-bit x
    localparam int RCP_SH = 32;
    localparam logic [RCP_SH:0] RECIP = (RCP_SH+1)'((64'd1 << RCP_SH) / DUTY_SCALE + 1);
    localparam int Q_W    = X_W + RCP_SH + 1;

    // per-wheel state
    logic signed [SUM_W-1:0]  err_sum_reg, err_sum_next;
    logic signed [ERR_W-1:0]  prev_err_reg, prev_err_next;
    logic [DUTY_W-1:0]        drive_duty_reg, drive_duty_next;
    logic [DUTY_W-1:0]        turn_duty_reg, turn_duty_next;

    // stage payloads
    logic signed [ERR_W-1:0]  err1_reg;
    logic signed [SUM_W-1:0]  sum1_reg;
    logic signed [DIFF_W-1:0] diff1_reg;
    logic signed [P_W-1:0]    p2_reg;
    logic signed [I_W-1:0]    i2_reg;
    logic signed [D_W-1:0]    d2_reg;
    logic signed [INC_W-1:0]  inc3_reg;
    logic [DUTY_W-1:0]        duty4_reg, duty4_next;

    logic signed [ERR_W-1:0]  err;
    logic signed [SUM_W:0]    sum_wide;
    logic signed [SUM_W-1:0]  sum_sat;
    logic signed [DIFF_W-1:0] diff;

    logic signed [ACC_W-1:0]  acc_sum;
    logic [DUTY_W-1:0]        acc_base;
    logic [DUTY_W-1:0]        acc_top;
    logic [DUTY_W-1:0]        duty_clamped;

    logic [X_W-1:0]           x;
    logic [Q_W-1:0]           q_prod;
    logic [Q_W-RCP_SH-1:0]    q;

    // stage 1: error terms
    always_comb
    begin
        err      = $signed({1'b0, target}) - $signed({1'b0, speed});
        sum_wide = {err_sum_reg[SUM_W-1], err_sum_reg}
                 + {{(SUM_W+1-ERR_W){err[ERR_W-1]}}, err};
        if (sum_wide[SUM_W] != sum_wide[SUM_W-1])
            sum_sat = sum_wide[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}}
                                      : {1'b0, {(SUM_W-1){1'b1}}};
        else
            sum_sat = sum_wide[SUM_W-1:0];
        diff = {err[ERR_W-1], err} - {prev_err_reg[ERR_W-1], prev_err_reg};

        err_sum_next  = err_sum_reg;
        prev_err_next = prev_err_reg;
        if (ctrl.ld[0])
        begin
            if (ctrl.in_restart)
            begin
                err_sum_next  = '0;
                prev_err_next = '0;
            end
            else
            begin
                err_sum_next  = sum_sat;
                prev_err_next = err;
            end
        end
    end

    // stage 4: accumulate and clamp to 0..limit, or reset the duties on restart
    always_comb
    begin
        acc_base = ctrl.s3_turn ? turn_duty_reg : drive_duty_reg;
        acc_top  = {limit, {FRAC{1'b0}}};
        acc_sum  = $signed({{(ACC_W-DUTY_W){1'b0}}, acc_base})
                 + $signed({inc3_reg[INC_W-1], inc3_reg});
        if (acc_sum[ACC_W-1])
            duty_clamped = '0;
        else if (acc_sum > $signed({{(ACC_W-DUTY_W){1'b0}}, acc_top}))
            duty_clamped = acc_top;
        else
            duty_clamped = acc_sum[DUTY_W-1:0];

        drive_duty_next = drive_duty_reg;
        turn_duty_next  = turn_duty_reg;
        duty4_next      = duty4_reg;
        if (ctrl.ld[3])
        begin
            if (ctrl.s3_restart)
            begin
                drive_duty_next = '0;
                turn_duty_next  = fwpid_pkg::TURN_DUTY_RESET;
                duty4_next      = '0;
            end
            else
            begin
                duty4_next = duty_clamped;
                if (ctrl.s3_turn)
                    turn_duty_next = duty_clamped;
                else
                    drive_duty_next = duty_clamped;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            err_sum_reg    <= '0;
            prev_err_reg   <= '0;
            drive_duty_reg <= '0;
            turn_duty_reg  <= fwpid_pkg::TURN_DUTY_RESET;
        end
        else
        begin
            err_sum_reg    <= err_sum_next;
            prev_err_reg   <= prev_err_next;
            drive_duty_reg <= drive_duty_next;
            turn_duty_reg  <= turn_duty_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.ld[0])
        begin
            err1_reg  <= err;
            sum1_reg  <= sum_sat;
            diff1_reg <= diff;
        end
        if (ctrl.ld[1])
        begin
            p2_reg <= $signed({1'b0, gains.kp}) * err1_reg;
            i2_reg <= $signed({1'b0, gains.ki}) * sum1_reg;
            d2_reg <= $signed({1'b0, gains.kd}) * diff1_reg;
        end
        if (ctrl.ld[2])
        begin
            inc3_reg <= INC_W'(p2_reg) + INC_W'(i2_reg) + INC_W'(d2_reg);
        end
        duty4_reg <= duty4_next;
    end

    // compare = floor(integer duty / DUTY_SCALE), saturated
    always_comb
    begin
        x      = duty4_reg[DUTY_W-1:FRAC];
        q_prod = Q_W'(x) * Q_W'(RECIP);
        q      = q_prod[Q_W-1:RCP_SH];
        if (q > (Q_W-RCP_SH)'(fwpid_pkg::CMP_MAX))
            compare = fwpid_pkg::CMP_MAX;
        else
            compare = q[fwpid_pkg::CMP_W-1:0];
    end

endmodule

/* sv/four_wheel_incremental_pid.sv */
// Top level of the four-wheel incremental PID controller.
//
//  channel   | signals                                   | word
//  ----------+-------------------------------------------+--------------------
//  request   | req_valid, req_ready, req_data            | mode, speeds, targets
//  response  | rsp_valid, rsp_ready, rsp_data            | four compare values
//  config    | psel, penable, pwrite, paddr, pwdata,     | gains, duty limit
//            | prdata, pready                            |
//
// Five-stage pipeline, one word per cycle while rsp_ready stays high.
// Stages: error terms, gain multipliers, increment sum, accumulate/clamp,
// compare (reciprocal multiply) into the response register.
// Stages hold independently, so bubbles close up while the output stalls.
// Reset (rst_n low) restores gains, duty limit and all wheel state at once.
module four_wheel_incremental_pid
#(
    parameter int DUTY_SCALE = fwpid_pkg::DUTY_SCALE_DEF,
    parameter int WHEELS     = fwpid_pkg::WHEELS_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          req_valid,
    output logic                          req_ready,
    input  fwpid_pkg::in_t                req_data,
    output logic                          rsp_valid,
    input  logic                          rsp_ready,
    output fwpid_pkg::out_t               rsp_data,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [fwpid_pkg::ADDR_W-1:0]  paddr,
    input  logic [fwpid_pkg::DATA_W-1:0]  pwdata,
    output logic [fwpid_pkg::DATA_W-1:0]  prdata,
    output logic                          pready
);

    localparam int NW = fwpid_pkg::MAX_WHEELS;

    fwpid_pkg::cfg_t    cfg;
    fwpid_pkg::ctrl_t   ctrl;
    fwpid_pkg::gains_t  gains;
    fwpid_pkg::out_t    rsp_reg, rsp_next;

    logic [fwpid_pkg::SPEED_W-1:0] speed  [NW];
    logic [fwpid_pkg::SPEED_W-1:0] target [NW];
    logic [fwpid_pkg::CMP_W-1:0]   cmp    [NW];

    fwpid_cfg u_cfg
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    fwpid_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .mode      (req_data.mode),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .ctrl      (ctrl)
    );

    // gain set follows the mode of the word in stage 1
    always_comb
    begin
        if (ctrl.s1_turn)
        begin
            gains.kp = cfg.turn_p;
            gains.ki = cfg.turn_i;
            gains.kd = cfg.turn_d;
        end
        else
        begin
            gains.kp = cfg.drive_p;
            gains.ki = cfg.drive_i;
            gains.kd = cfg.drive_d;
        end
    end

    assign speed[0]  = req_data.speed_a;
    assign target[0] = req_data.target_a;
    assign speed[1]  = req_data.speed_b;
    assign target[1] = req_data.target_b;
    assign speed[2]  = req_data.speed_c;
    assign target[2] = req_data.target_c;
    assign speed[3]  = req_data.speed_d;
    assign target[3] = req_data.target_d;

    for (genvar w = 0; w < NW; w++)
    begin : g_lane
        if (w < WHEELS)
        begin : g_on
            fwpid_lane
            #(
                .DUTY_SCALE (DUTY_SCALE)
            )
            u_lane
            (
                .clk     (clk),
                .rst_n   (rst_n),
                .ctrl    (ctrl),
                .speed   (speed[w]),
                .target  (target[w]),
                .gains   (gains),
                .limit   (cfg.limit),
                .compare (cmp[w])
            );
        end
        else
        begin : g_off
            assign cmp[w] = '0;
        end
    end

    // merge stage: collect the lane results into the response word
    always_comb
    begin
        rsp_next = rsp_reg;
        if (ctrl.ld[fwpid_pkg::STAGES-1])
        begin
            rsp_next.compare_a = cmp[0];
            rsp_next.compare_b = cmp[1];
            rsp_next.compare_c = cmp[2];
            rsp_next.compare_d = cmp[3];
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
    end

    assign rsp_data = rsp_reg;

endmodule

/* bench/tb_top.sv */
`timescale 1ns / 100ps
// Self-checking testbench for the four-wheel incremental PID controller.
module tb_top;

    typedef logic [fwpid_pkg::SPEED_W-1:0] wheel_vals_t [fwpid_pkg::MAX_WHEELS];

    localparam logic [2:0] REG_NONE = 3'd7;   // unmapped register slot

    class pid_scoreboard;
        bit [fwpid_pkg::GAIN_W-1:0]       gain       [6];
        bit [fwpid_pkg::LIMIT_W-1:0]      limit;
        bit [fwpid_pkg::DUTY_W-1:0]       drive_duty [fwpid_pkg::MAX_WHEELS];
        bit [fwpid_pkg::DUTY_W-1:0]       turn_duty  [fwpid_pkg::MAX_WHEELS];
        bit signed [fwpid_pkg::ERR_W-1:0] last_err   [fwpid_pkg::MAX_WHEELS];
        bit signed [fwpid_pkg::SUM_W-1:0] err_sum    [fwpid_pkg::MAX_WHEELS];
        fwpid_pkg::out_t                  expected_compares [$];
        int                               errors;

        function new();
            gain[fwpid_pkg::REG_DRIVE_P] = fwpid_pkg::DRIVE_P_RESET;
            gain[fwpid_pkg::REG_DRIVE_I] = fwpid_pkg::DRIVE_I_RESET;
            gain[fwpid_pkg::REG_DRIVE_D] = fwpid_pkg::DRIVE_D_RESET;
            gain[fwpid_pkg::REG_TURN_P]  = fwpid_pkg::TURN_P_RESET;
            gain[fwpid_pkg::REG_TURN_I]  = fwpid_pkg::TURN_I_RESET;
            gain[fwpid_pkg::REG_TURN_D]  = fwpid_pkg::TURN_D_RESET;
            limit  = fwpid_pkg::LIMIT_RESET;
            errors = 0;
            clear_wheels();
        endfunction

        function void clear_wheels();
            for (int w = 0; w < fwpid_pkg::MAX_WHEELS; w++)
            begin
                drive_duty[w] = '0;
                turn_duty[w]  = fwpid_pkg::TURN_DUTY_RESET;
                last_err[w]   = '0;
                err_sum[w]    = '0;
            end
        endfunction

        function void note_error(string msg);
            errors++;
            $display("%s", msg);
        endfunction

        function void set_register(logic [2:0] idx, logic [fwpid_pkg::DATA_W-1:0] d);
            if (idx == fwpid_pkg::REG_LIMIT)
                limit = d[fwpid_pkg::LIMIT_W-1:0];
            else if (idx < fwpid_pkg::REG_LIMIT)
                gain[idx] = d[fwpid_pkg::GAIN_W-1:0];
        endfunction

        function logic [fwpid_pkg::DATA_W-1:0] register_value(logic [2:0] idx);
            if (idx == fwpid_pkg::REG_LIMIT)
                return fwpid_pkg::DATA_W'(limit);
            return fwpid_pkg::DATA_W'(gain[idx]);
        endfunction

        function int pending();
            return expected_compares.size();
        endfunction

        // update wheel state for an accepted word and queue its compare values
        function void predict_compares(fwpid_pkg::in_t c);
            longint kp, ki, kd, ceiling, e, s, df, inc, duty, q;
            longint sum_hi, sum_lo;
            bit turn;
            wheel_vals_t sp, tg;
            bit [fwpid_pkg::CMP_W-1:0] cmp [fwpid_pkg::MAX_WHEELS];
            fwpid_pkg::out_t o;

            if (c.mode == fwpid_pkg::MODE_RESTART || c.mode == fwpid_pkg::MODE_SPARE)
            begin
                clear_wheels();
                expected_compares.push_back('0);
                return;
            end
            turn = (c.mode == fwpid_pkg::MODE_TURN);
            kp = longint'(turn ? gain[fwpid_pkg::REG_TURN_P] : gain[fwpid_pkg::REG_DRIVE_P]);
            ki = longint'(turn ? gain[fwpid_pkg::REG_TURN_I] : gain[fwpid_pkg::REG_DRIVE_I]);
            kd = longint'(turn ? gain[fwpid_pkg::REG_TURN_D] : gain[fwpid_pkg::REG_DRIVE_D]);
            ceiling = longint'(limit) << fwpid_pkg::FRAC_BITS;
            sum_hi = (longint'(1) << (fwpid_pkg::SUM_W - 1)) - 1;
            sum_lo = -(longint'(1) << (fwpid_pkg::SUM_W - 1));
            sp = '{c.speed_a, c.speed_b, c.speed_c, c.speed_d};
            tg = '{c.target_a, c.target_b, c.target_c, c.target_d};
            for (int w = 0; w < fwpid_pkg::MAX_WHEELS; w++)
                cmp[w] = '0;
            for (int w = 0; w < fwpid_pkg::WHEELS_DEF; w++)
            begin
                e  = longint'(tg[w]) - longint'(sp[w]);
                s  = longint'(err_sum[w]) + e;
                df = e - longint'(last_err[w]);
                if (s > sum_hi)
                    s = sum_hi;
                if (s < sum_lo)
                    s = sum_lo;
                err_sum[w]  = s[fwpid_pkg::SUM_W-1:0];
                last_err[w] = e[fwpid_pkg::ERR_W-1:0];
                inc  = kp * e + ki * s + kd * df;
                duty = inc + longint'(turn ? turn_duty[w] : drive_duty[w]);
                if (duty < 0)
                    duty = 0;
                else if (duty > ceiling)
                    duty = ceiling;
                if (turn)
                    turn_duty[w] = duty[fwpid_pkg::DUTY_W-1:0];
                else
                    drive_duty[w] = duty[fwpid_pkg::DUTY_W-1:0];
                q = (duty >>> fwpid_pkg::FRAC_BITS) / fwpid_pkg::DUTY_SCALE_DEF;
                if (q > longint'(fwpid_pkg::CMP_MAX))
                    q = longint'(fwpid_pkg::CMP_MAX);
                cmp[w] = q[fwpid_pkg::CMP_W-1:0];
            end
            o.compare_a = cmp[0];
            o.compare_b = cmp[1];
            o.compare_c = cmp[2];
            o.compare_d = cmp[3];
            expected_compares.push_back(o);
        endfunction

        function void check_compares(fwpid_pkg::out_t got);
            fwpid_pkg::out_t want;
            logic [fwpid_pkg::CMP_W-1:0] g [fwpid_pkg::MAX_WHEELS];
            logic [fwpid_pkg::CMP_W-1:0] x [fwpid_pkg::MAX_WHEELS];

            if (expected_compares.size() == 0)
            begin
                note_error($sformatf("%0t: unexpected response word %h", $time, got));
                return;
            end
            want = expected_compares.pop_front();
            g = '{got.compare_a, got.compare_b, got.compare_c, got.compare_d};
            x = '{want.compare_a, want.compare_b, want.compare_c, want.compare_d};
            for (int w = 0; w < fwpid_pkg::MAX_WHEELS; w++)
                if (g[w] !== x[w])
                    note_error($sformatf("%0t: compare_%c expected %0d, got %0d",
                                         $time, 8'("a" + w), x[w], g[w]));
        endfunction
    endclass

    logic                          clk       = 1'b0;
    logic                          rst_n     = 1'b0;
    logic                          req_valid = 1'b0;
    logic                          req_ready;
    fwpid_pkg::in_t                req_data  = '0;
    logic                          rsp_valid;
    logic                          rsp_ready = 1'b0;
    fwpid_pkg::out_t               rsp_data;
    logic                          psel      = 1'b0;
    logic                          penable   = 1'b0;
    logic                          pwrite    = 1'b0;
    logic [fwpid_pkg::ADDR_W-1:0]  paddr     = '0;
    logic [fwpid_pkg::DATA_W-1:0]  pwdata    = '0;
    logic [fwpid_pkg::DATA_W-1:0]  prdata;
    logic                          pready;

    pid_scoreboard pid_sb;
    bit            steady = 1'b0;   // no idle gaps on either side while set

    four_wheel_incremental_pid dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req_data  (req_data),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp_data  (rsp_data),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    initial
    begin
        #25_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    function automatic int pick_gap();
        int r;
        if (steady)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // response side stalls
    initial
    begin
        int g;
        forever
        begin
            g = pick_gap();
            if (g > 0)
            begin
                rsp_ready <= 1'b0;
                repeat (g) @(posedge clk);
            end
            rsp_ready <= 1'b1;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (req_valid && req_ready)
                pid_sb.predict_compares(req_data);
            if (rsp_valid && rsp_ready)
                pid_sb.check_compares(rsp_data);
        end
    end

    task automatic send_cmd(input fwpid_pkg::in_t c);
        int g;
        g = pick_gap();
        if (g > 0)
        begin
            req_valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
        req_valid <= 1'b1;
        req_data  <= c;
        do
            @(posedge clk);
        while (!req_ready);
    endtask

    task automatic idle_until_drained();
        req_valid <= 1'b0;
        // wait for a clock edge first so the last accepted word is already queued
        @(posedge clk);
        while (pid_sb.pending() != 0)
            @(posedge clk);
        repeat (fwpid_pkg::STAGES + 3) @(posedge clk);
    endtask

    task automatic apb_write(input logic [2:0] idx, input logic [fwpid_pkg::DATA_W-1:0] d);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= d;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        pid_sb.set_register(idx, d);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic apb_read(input logic [2:0] idx, output logic [fwpid_pkg::DATA_W-1:0] d);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        d = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic apply_setting(input int ph);
        logic [fwpid_pkg::DATA_W-1:0] v [7];
        logic [fwpid_pkg::DATA_W-1:0] rb;
        logic [fwpid_pkg::DATA_W-1:0] mask;
        int i;

        case (ph)
            1:
                for (i = 0; i < 7; i++)
                    v[i] = 32'hFFFF_FFFF;
            3:
                for (i = 0; i < 7; i++)
                    v[i] = '0;
            4, 7:
            begin
                v[fwpid_pkg::REG_DRIVE_P] = fwpid_pkg::DATA_W'(fwpid_pkg::DRIVE_P_RESET);
                v[fwpid_pkg::REG_DRIVE_I] = fwpid_pkg::DATA_W'(fwpid_pkg::DRIVE_I_RESET);
                v[fwpid_pkg::REG_DRIVE_D] = fwpid_pkg::DATA_W'(fwpid_pkg::DRIVE_D_RESET);
                v[fwpid_pkg::REG_TURN_P]  = fwpid_pkg::DATA_W'(fwpid_pkg::TURN_P_RESET);
                v[fwpid_pkg::REG_TURN_I]  = fwpid_pkg::DATA_W'(fwpid_pkg::TURN_I_RESET);
                v[fwpid_pkg::REG_TURN_D]  = fwpid_pkg::DATA_W'(fwpid_pkg::TURN_D_RESET);
                v[fwpid_pkg::REG_LIMIT]   = (ph == 4) ? 32'hFFFF_FFFF :
                                            fwpid_pkg::DATA_W'(fwpid_pkg::LIMIT_RESET);
            end
            5:
                for (i = 0; i < 7; i++)
                    v[i] = $urandom;
            default:
            begin
                // gains of a few units so the duty moves inside its range
                for (i = 0; i < 6; i++)
                    v[i] = (i % 3 == 0) ? $urandom_range(0, 1 << 23) :
                           (i % 3 == 1) ? $urandom_range(0, 1 << 14) :
                                          $urandom_range(0, 1 << 22);
                v[fwpid_pkg::REG_LIMIT] = (ph == 2) ? 32'h0000_FFFF :
                                          (ph == 6) ? $urandom_range(1, 200) :
                                                      $urandom_range(1000, 65535);
            end
        endcase
        for (i = 0; i < 7; i++)
            apb_write(3'(i), v[i]);
        if (ph == 7)
            apb_write(REG_NONE, $urandom);
        for (i = 0; i < 7; i++)
        begin
            apb_read(3'(i), rb);
            mask = (3'(i) == fwpid_pkg::REG_LIMIT) ?
                   fwpid_pkg::DATA_W'({fwpid_pkg::LIMIT_W{1'b1}}) :
                   fwpid_pkg::DATA_W'({fwpid_pkg::GAIN_W{1'b1}});
            if ((rb & mask) !== pid_sb.register_value(3'(i)))
                pid_sb.note_error($sformatf("%0t: register %0d expected %0h, got %0h",
                                            $time, i, pid_sb.register_value(3'(i)), rb));
        end
    endtask

    function automatic fwpid_pkg::in_t pack_cmd(logic [fwpid_pkg::MODE_W-1:0] m,
                                                wheel_vals_t sp, wheel_vals_t tg);
        fwpid_pkg::in_t c;
        c.mode     = m;
        c.speed_a  = sp[0];
        c.target_a = tg[0];
        c.speed_b  = sp[1];
        c.target_b = tg[1];
        c.speed_c  = sp[2];
        c.target_c = tg[2];
        c.speed_d  = sp[3];
        c.target_d = tg[3];
        return c;
    endfunction

    function automatic fwpid_pkg::in_t uniform_cmd(logic [fwpid_pkg::MODE_W-1:0] m,
                                                   logic [fwpid_pkg::SPEED_W-1:0] s,
                                                   logic [fwpid_pkg::SPEED_W-1:0] t);
        wheel_vals_t sp, tg;
        for (int w = 0; w < fwpid_pkg::MAX_WHEELS; w++)
        begin
            sp[w] = s;
            tg[w] = t;
        end
        return pack_cmd(m, sp, tg);
    endfunction

    function automatic logic [fwpid_pkg::SPEED_W-1:0] corner_value();
        case ($urandom_range(0, 2))
            0:       return '0;
            1:       return '1;
            default: return fwpid_pkg::SPEED_W'($urandom);
        endcase
    endfunction

    // mostly speeds close to their setpoint, so duties wander instead of pinning
    function automatic fwpid_pkg::in_t random_cmd();
        wheel_vals_t sp, tg;
        logic [fwpid_pkg::MODE_W-1:0] m;
        int r, k, d;

        r = $urandom_range(0, 99);
        m = (r < 4) ? fwpid_pkg::MODE_RESTART : (r < 5) ? fwpid_pkg::MODE_SPARE :
            (r < 55) ? fwpid_pkg::MODE_DRIVE : fwpid_pkg::MODE_TURN;
        for (int w = 0; w < fwpid_pkg::MAX_WHEELS; w++)
        begin
            k = $urandom_range(0, 99);
            if (k < 65)
            begin
                tg[w] = fwpid_pkg::SPEED_W'($urandom);
                d = int'($urandom_range(0, 400)) - 200 + int'(tg[w]);
                if (d < 0)
                    d = 0;
                if (d > 65535)
                    d = 65535;
                sp[w] = fwpid_pkg::SPEED_W'(d);
            end
            else if (k < 85)
            begin
                sp[w] = fwpid_pkg::SPEED_W'($urandom);
                tg[w] = fwpid_pkg::SPEED_W'($urandom);
            end
            else
            begin
                sp[w] = corner_value();
                tg[w] = corner_value();
            end
        end
        return pack_cmd(m, sp, tg);
    endfunction

    initial
    begin
        wheel_vals_t sp, tg;
        fwpid_pkg::in_t sat;
        int n;

        pid_sb = new();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed words at reset gains
        send_cmd(uniform_cmd(fwpid_pkg::MODE_DRIVE, '0, '0));
        send_cmd(uniform_cmd(fwpid_pkg::MODE_DRIVE, '0, '1));
        send_cmd(uniform_cmd(fwpid_pkg::MODE_DRIVE, '0, '1));
        send_cmd(uniform_cmd(fwpid_pkg::MODE_DRIVE, '1, '0));
        send_cmd(uniform_cmd(fwpid_pkg::MODE_TURN, '0, '1));
        send_cmd(uniform_cmd(fwpid_pkg::MODE_TURN, '1, '0));
        send_cmd(uniform_cmd(fwpid_pkg::MODE_TURN, 16'd1234, 16'd1234));
        send_cmd(uniform_cmd(fwpid_pkg::MODE_RESTART, '1, '1));
        sp = '{16'd0, 16'hFFFF, 16'd500, 16'd30000};
        tg = '{16'hFFFF, 16'd0, 16'd500, 16'd30010};
        send_cmd(pack_cmd(fwpid_pkg::MODE_DRIVE, sp, tg));
        send_cmd(uniform_cmd(fwpid_pkg::MODE_SPARE, '0, '1));
        send_cmd(uniform_cmd(fwpid_pkg::MODE_TURN, 16'd100, 16'd103));
        send_cmd(uniform_cmd(fwpid_pkg::MODE_TURN, 16'd100, 16'd103));
        repeat (3) send_cmd(uniform_cmd(fwpid_pkg::MODE_DRIVE, 16'd1000, 16'd1010));
        send_cmd(uniform_cmd(fwpid_pkg::MODE_DRIVE, 16'd1010, 16'd1000));
        repeat (4) send_cmd(random_cmd());
        idle_until_drained();

        for (int ph = 0; ph < 8; ph++)
        begin
            idle_until_drained();
            apply_setting(ph);
            steady = (ph == 6);
            repeat (150) send_cmd(random_cmd());
        end

        // full-scale errors back to back: a,b run up, c,d run down, max integral gain
        idle_until_drained();
        steady = 1'b1;
        apb_write(fwpid_pkg::REG_DRIVE_I, 32'h7FFF_FFFF);
        send_cmd(uniform_cmd(fwpid_pkg::MODE_RESTART, '0, '0));
        sp = '{16'd0, 16'd0, 16'hFFFF, 16'hFFFF};
        tg = '{16'hFFFF, 16'hFFFF, 16'd0, 16'd0};
        sat = pack_cmd(fwpid_pkg::MODE_DRIVE, sp, tg);
        repeat (60) send_cmd(sat);
        sat = pack_cmd(fwpid_pkg::MODE_DRIVE, tg, sp);
        repeat (20) send_cmd(sat);
        send_cmd(uniform_cmd(fwpid_pkg::MODE_RESTART, '1, '0));
        steady = 1'b0;
        repeat (20) send_cmd(random_cmd());

        req_valid <= 1'b0;
        @(posedge clk);
        n = 0;
        while (pid_sb.pending() != 0 && n < 5000)
        begin
            @(posedge clk);
            n++;
        end
        repeat (fwpid_pkg::STAGES + 5) @(posedge clk);
        if (pid_sb.pending() != 0)
            pid_sb.note_error($sformatf("%0t: %0d response words never arrived",
                                        $time, pid_sb.pending()));
        if (pid_sb.errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

/* filelist.f */
sv/fwpid_pkg.sv
sv/fwpid_cfg.sv
sv/fwpid_ctrl.sv
sv/fwpid_lane.sv
sv/four_wheel_incremental_pid.sv
bench/tb_top.sv
